>>> sv/cnms_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cnms_pkg
// Shared constants and types of the Canny non-maximum suppression block.
// ----------------------------------------------------------------------------
package cnms_pkg;

  localparam int WIDTH_REG_BITS  = 11;
  localparam int HEIGHT_REG_BITS = 13;
  localparam int THR_BITS        = 16;
  localparam int CFG_INDEX_BITS  = 2;
  localparam int CFG_DATA_BITS   = 16;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_IMAGE_WIDTH   = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_IMAGE_HEIGHT  = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_LOW_THRESHOLD = 2'd2;

  localparam logic [WIDTH_REG_BITS-1:0]  RST_IMAGE_WIDTH  = 11'd640;
  localparam logic [HEIGHT_REG_BITS-1:0] RST_IMAGE_HEIGHT = 13'd480;

  localparam int ROW_BITS     = 13;
  localparam int OUT_ROW_BITS = 12;
  localparam logic [ROW_BITS-1:0] HEIGHT_LIMIT = 13'd4096;

  localparam logic ACT_FLUSH = 1'b1;

  localparam int OUTQ_DEPTH = 8;
  localparam int OUTQ_AW    = $clog2(OUTQ_DEPTH);
  localparam int PEND_BITS  = $clog2(OUTQ_DEPTH + 1);

  typedef struct packed {
    logic emit;
    logic zero;
    logic last;
  } tag_t;

  typedef struct packed {
    logic edge_res;
    logic frame_last;
  } res_t;

endpackage

`default_nettype wire

>>> sv/cnms_decide.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cnms_decide
// Three-stage edge decision: direction select, cross products, compare.
// ----------------------------------------------------------------------------
module cnms_decide #(
  parameter int MAG_BITS  = 16,
  parameter int GRAD_BITS = 16
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire cnms_pkg::tag_t                        tag,
  input  wire logic [8:0][MAG_BITS-1:0]              win,
  input  wire logic [GRAD_BITS-1:0]                  grad_v,
  input  wire logic [GRAD_BITS-1:0]                  grad_h,
  input  wire logic                                  mask,
  input  wire logic [cnms_pkg::THR_BITS-1:0]         threshold,
  output logic                                       done,
  output cnms_pkg::res_t                             result
);

  localparam int P  = MAG_BITS + GRAD_BITS;
  localparam int TW = (MAG_BITS > cnms_pkg::THR_BITS) ? MAG_BITS : cnms_pkg::THR_BITS;

  logic [GRAD_BITS-1:0] ay, ax, num, den;
  logic                 gy_zero, gx_zero, up, down, right, left, dneg, ok;
  logic [MAG_BITS-1:0]  va, vb, vc, vd;

  cnms_pkg::tag_t       a_tag;
  logic                 a_ok;
  logic [MAG_BITS-1:0]  a_m, a_va, a_vb, a_vc, a_vd;
  logic [GRAD_BITS-1:0] a_num, a_den, a_dmn;

  cnms_pkg::tag_t       b_tag;
  logic                 b_ok;
  logic [P-1:0]         b_rhs, b_pa, b_pb, b_pc, b_pd;
  logic [P:0]           lhs1, lhs2, rhs;

  always_comb begin
    ay = grad_v[GRAD_BITS-1] ? (~grad_v + GRAD_BITS'(1)) : grad_v;
    ax = grad_h[GRAD_BITS-1] ? (~grad_h + GRAD_BITS'(1)) : grad_h;
    gy_zero = (grad_v == '0);
    gx_zero = (grad_h == '0);
    up    = !grad_v[GRAD_BITS-1];
    down  = grad_v[GRAD_BITS-1] || gy_zero;
    right = !grad_h[GRAD_BITS-1];
    left  = grad_h[GRAD_BITS-1] || gx_zero;
    dneg  = (up && right) || (down && left);
    if (dneg && (ay > ax)) begin
      num = ax; den = ay; va = win[7]; vb = win[8]; vc = win[1]; vd = win[0];
    end else if (dneg) begin
      num = ay; den = ax; va = win[5]; vb = win[8]; vc = win[3]; vd = win[0];
    end else if (ay < ax) begin
      num = ay; den = ax; va = win[5]; vb = win[2]; vc = win[3]; vd = win[6];
    end else begin
      num = ax; den = ay; va = win[1]; vb = win[2]; vc = win[7]; vd = win[6];
    end
    ok = mask && !tag.zero && !(gy_zero && gx_zero)
         && (TW'(win[4]) >= TW'(threshold));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_tag <= '0;
      b_tag <= '0;
    end else begin
      a_tag <= tag;
      b_tag <= a_tag;
    end
  end

  always_ff @(posedge clk) begin
    a_ok  <= ok;
    a_m   <= win[4];
    a_num <= num;
    a_den <= den;
    a_dmn <= den - num;
    a_va  <= va;
    a_vb  <= vb;
    a_vc  <= vc;
    a_vd  <= vd;
    b_ok  <= a_ok;
    b_rhs <= P'(a_m) * P'(a_den);
    b_pb  <= P'(a_vb) * P'(a_num);
    b_pa  <= P'(a_va) * P'(a_dmn);
    b_pd  <= P'(a_vd) * P'(a_num);
    b_pc  <= P'(a_vc) * P'(a_dmn);
  end

  always_comb begin
    lhs1 = {1'b0, b_pb} + {1'b0, b_pa};
    lhs2 = {1'b0, b_pd} + {1'b0, b_pc};
    rhs  = {1'b0, b_rhs};
    done = b_tag.emit;
    result.edge_res   = b_ok && (lhs1 <= rhs) && (lhs2 <= rhs);
    result.frame_last = b_tag.last;
  end

endmodule

`default_nettype wire

>>> sv/cnms_outq.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cnms_outq
// Small result queue between the decision pipeline and the output channel.
// ----------------------------------------------------------------------------
module cnms_outq (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire cnms_pkg::res_t din,
  input  wire logic           pop,
  output logic                valid,
  output cnms_pkg::res_t      dout
);

  cnms_pkg::res_t                   q [cnms_pkg::OUTQ_DEPTH];
  logic [cnms_pkg::OUTQ_AW-1:0]     wr_ptr, rd_ptr;
  logic [cnms_pkg::PEND_BITS-1:0]   count, count_next;

  always_comb begin
    count_next = count + cnms_pkg::PEND_BITS'(push) - cnms_pkg::PEND_BITS'(pop);
    valid      = (count != '0);
    dout       = q[rd_ptr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + cnms_pkg::OUTQ_AW'(1);
      if (pop)  rd_ptr <= rd_ptr + cnms_pkg::OUTQ_AW'(1);
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push) q[wr_ptr] <= din;
  end

endmodule

`default_nettype wire

>>> sv/canny_nonmax_suppression.sv
`default_nettype none
// ----------------------------------------------------------------------------
// canny_nonmax_suppression
// Streaming Canny non-maximum suppression with interpolated neighbors.
//
// Takes one item per clock while pix_stall is low. Each pixel does one read and
// one write of the two line memories (magnitude pair and gradient/mask), the
// write in the cycle after the read, with the written word forwarded when the
// next pixel reads the same column. A result passes the s1, s2, decide a and b
// registers and waits in an 8-entry queue; pix_stall rises only in reset or
// while 8 results are pending. Results lag the input by one row plus one
// pixel; flush items drain the last row plus one pixel once the frame is in.
// Writing the width or height restarts the frame. Line memories have no
// clearing pass; unwritten entries only feed border pixels, which always give 0.
// ----------------------------------------------------------------------------
module canny_nonmax_suppression #(
  parameter int MAX_WIDTH = 1024,
  parameter int MAG_BITS  = 16,
  parameter int GRAD_BITS = 16
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   pix_valid,
  output logic                                        pix_stall,
  input  wire logic                                   action,
  input  wire logic [MAG_BITS-1:0]                    magnitude,
  input  wire logic signed [GRAD_BITS-1:0]            grad_vertical,
  input  wire logic signed [GRAD_BITS-1:0]            grad_horizontal,
  input  wire logic                                   mask_bit,
  output logic                                        res_valid,
  input  wire logic                                   res_stall,
  output logic                                        edge_res,
  output logic                                        frame_last,
  input  wire logic                                   cfg_valid,
  output logic                                        cfg_ready,
  input  wire logic [cnms_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
  input  wire logic [cnms_pkg::CFG_DATA_BITS-1:0]     cfg_data
);

  localparam int COL_BITS = $clog2(MAX_WIDTH);
  localparam int WID_BITS = $clog2(MAX_WIDTH + 1);
  localparam int EXT_BITS = (WID_BITS > cnms_pkg::WIDTH_REG_BITS) ?
                            WID_BITS : cnms_pkg::WIDTH_REG_BITS;
  localparam int RB       = cnms_pkg::ROW_BITS;
  localparam int GW       = 2 * GRAD_BITS + 1;

  logic [cnms_pkg::WIDTH_REG_BITS-1:0]  image_width;
  logic [cnms_pkg::HEIGHT_REG_BITS-1:0] image_height;
  logic [cnms_pkg::THR_BITS-1:0]        low_threshold;

  logic [EXT_BITS-1:0]  w_ext, w_clamp;
  logic [WID_BITS-1:0]  w_eff, w_m1;
  logic [COL_BITS-1:0]  col_last;
  logic [RB-1:0]        h_eff, h_m1, out_row_ext;

  logic [RB-1:0]                     in_row;
  logic [COL_BITS-1:0]               in_col;
  logic [cnms_pkg::OUT_ROW_BITS-1:0] out_row;
  logic [COL_BITS-1:0]               out_col;

  logic cfg_wr, geo_wr, pix_acc, is_flush, all_in, pix_go, flush_go;
  logic pix_emit, emit, border, last, pop;
  cnms_pkg::tag_t tag;

  logic [cnms_pkg::PEND_BITS-1:0] pending, pending_next;

  logic [2*MAG_BITS-1:0] mag_mem [MAX_WIDTH];
  logic [GW-1:0]         grad_mem [MAX_WIDTH];
  logic [2*MAG_BITS-1:0] mag_rd, mag_use, mag_wr, fwd_mag;
  logic [GW-1:0]         grad_rd, grad_use, grad_wr, fwd_grad;
  logic                  fwd_hit;

  logic                  s1_upd;
  cnms_pkg::tag_t        s1_tag;
  logic [COL_BITS-1:0]   s1_col;
  logic [MAG_BITS-1:0]   s1_mag;
  logic [GRAD_BITS-1:0]  s1_gv, s1_gh;
  logic                  s1_mk;
  logic [MAG_BITS-1:0]   top, mid;

  logic [8:0][MAG_BITS-1:0] win, win_next;
  logic [GRAD_BITS-1:0]     cg_gv, cg_gh;
  logic                     cg_mk;

  cnms_pkg::tag_t           s2_tag;
  logic [8:0][MAG_BITS-1:0] s2_win;
  logic [GRAD_BITS-1:0]     s2_gv, s2_gh;
  logic                     s2_mk;

  logic           dec_done, q_valid;
  cnms_pkg::res_t dec_res, q_res;

  always_comb begin
    w_ext   = EXT_BITS'(image_width);
    w_clamp = (w_ext == '0) ? EXT_BITS'(1) :
              (w_ext > EXT_BITS'(MAX_WIDTH)) ? EXT_BITS'(MAX_WIDTH) : w_ext;
    w_eff    = WID_BITS'(w_clamp);
    w_m1     = w_eff - WID_BITS'(1);
    col_last = w_m1[COL_BITS-1:0];
    h_eff = (image_height == '0) ? RB'(1) :
            (RB'(image_height) > cnms_pkg::HEIGHT_LIMIT) ? cnms_pkg::HEIGHT_LIMIT :
            RB'(image_height);
    h_m1        = h_eff - RB'(1);
    out_row_ext = RB'(out_row);

    cfg_ready = !rst;
    cfg_wr    = cfg_valid && cfg_ready;
    geo_wr    = cfg_wr && ((cfg_index == cnms_pkg::CFG_IMAGE_WIDTH) ||
                           (cfg_index == cnms_pkg::CFG_IMAGE_HEIGHT));

    pix_stall = rst || (pending == cnms_pkg::PEND_BITS'(cnms_pkg::OUTQ_DEPTH));
    pix_acc   = pix_valid && !pix_stall;
    is_flush  = (action == cnms_pkg::ACT_FLUSH);
    all_in    = (in_row == h_eff);
    pix_go    = pix_acc && !is_flush && !all_in;
    flush_go  = pix_acc && is_flush && all_in;
    pix_emit  = pix_go && ((|in_row[RB-1:1]) || (in_row[0] && (in_col != '0)));
    emit      = pix_emit || flush_go;
    last      = (out_row_ext == h_m1) && (out_col == col_last);
    border    = (out_row == '0) || (out_row_ext == h_m1) ||
                (out_col == '0) || (out_col == col_last);
    tag.emit  = emit;
    tag.zero  = flush_go || border;
    tag.last  = last;

    pop          = res_valid && !res_stall;
    pending_next = pending + cnms_pkg::PEND_BITS'(emit) - cnms_pkg::PEND_BITS'(pop);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width   <= cnms_pkg::RST_IMAGE_WIDTH;
      image_height  <= cnms_pkg::RST_IMAGE_HEIGHT;
      low_threshold <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_index)
        cnms_pkg::CFG_IMAGE_WIDTH:
          image_width <= cfg_data[cnms_pkg::WIDTH_REG_BITS-1:0];
        cnms_pkg::CFG_IMAGE_HEIGHT:
          image_height <= cfg_data[cnms_pkg::HEIGHT_REG_BITS-1:0];
        cnms_pkg::CFG_LOW_THRESHOLD:
          low_threshold <= cfg_data[cnms_pkg::THR_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst || geo_wr || (emit && last)) begin
      in_row  <= '0;
      in_col  <= '0;
      out_row <= '0;
      out_col <= '0;
    end else begin
      if (pix_go) begin
        if (in_col == col_last) begin
          in_col <= '0;
          in_row <= in_row + RB'(1);
        end else begin
          in_col <= in_col + COL_BITS'(1);
        end
      end
      if (emit) begin
        if (out_col == col_last) begin
          out_col <= '0;
          out_row <= out_row + cnms_pkg::OUT_ROW_BITS'(1);
        end else begin
          out_col <= out_col + COL_BITS'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
      s1_upd  <= 1'b0;
      s1_tag  <= '0;
      s2_tag  <= '0;
      fwd_hit <= 1'b0;
    end else begin
      pending <= pending_next;
      s1_upd  <= pix_go;
      s1_tag  <= tag;
      s2_tag  <= s1_tag;
      fwd_hit <= pix_go && s1_upd && (in_col == s1_col);
    end
  end

  always_ff @(posedge clk) begin
    s1_col   <= in_col;
    s1_mag   <= magnitude;
    s1_gv    <= grad_vertical;
    s1_gh    <= grad_horizontal;
    s1_mk    <= mask_bit;
    fwd_mag  <= mag_wr;
    fwd_grad <= grad_wr;
  end

  always_ff @(posedge clk) begin
    if (pix_go) begin
      mag_rd  <= mag_mem[in_col];
      grad_rd <= grad_mem[in_col];
    end
    if (s1_upd) begin
      mag_mem[s1_col]  <= mag_wr;
      grad_mem[s1_col] <= grad_wr;
    end
  end

  always_comb begin
    mag_use  = fwd_hit ? fwd_mag : mag_rd;
    grad_use = fwd_hit ? fwd_grad : grad_rd;
    top      = mag_use[MAG_BITS-1:0];
    mid      = mag_use[2*MAG_BITS-1:MAG_BITS];
    mag_wr   = {s1_mag, mid};
    grad_wr  = {s1_gv, s1_gh, s1_mk};
    win_next = win;
    if (s1_upd) begin
      win_next[0] = win[1];
      win_next[1] = win[2];
      win_next[2] = top;
      win_next[3] = win[4];
      win_next[4] = win[5];
      win_next[5] = mid;
      win_next[6] = win[7];
      win_next[7] = win[8];
      win_next[8] = s1_mag;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win   <= '0;
      cg_gv <= '0;
      cg_gh <= '0;
      cg_mk <= 1'b0;
    end else begin
      win <= win_next;
      if (s1_upd) begin
        cg_gv <= grad_use[GW-1:GRAD_BITS+1];
        cg_gh <= grad_use[GRAD_BITS:1];
        cg_mk <= grad_use[0];
      end
    end
  end

  always_ff @(posedge clk) begin
    s2_win <= win_next;
    s2_gv  <= cg_gv;
    s2_gh  <= cg_gh;
    s2_mk  <= cg_mk;
  end

  cnms_decide #(
    .MAG_BITS  (MAG_BITS),
    .GRAD_BITS (GRAD_BITS)
  ) u_decide (
    .clk       (clk),
    .rst       (rst),
    .tag       (s2_tag),
    .win       (s2_win),
    .grad_v    (s2_gv),
    .grad_h    (s2_gh),
    .mask      (s2_mk),
    .threshold (low_threshold),
    .done      (dec_done),
    .result    (dec_res)
  );

  cnms_outq u_outq (
    .clk   (clk),
    .rst   (rst),
    .push  (dec_done),
    .din   (dec_res),
    .pop   (pop),
    .valid (q_valid),
    .dout  (q_res)
  );

  always_comb begin
    res_valid  = q_valid && !rst;
    edge_res   = q_res.edge_res;
    frame_last = q_res.frame_last;
  end

endmodule

`default_nettype wire

>>> sv/cnms_check.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cnms_check
// Port-level checks for canny_nonmax_suppression, bound to the top level.
// ----------------------------------------------------------------------------
module cnms_check (
  input wire logic clk,
  input wire logic rst,
  input wire logic pix_valid,
  input wire logic pix_stall,
  input wire logic res_valid,
  input wire logic res_stall,
  input wire logic edge_res,
  input wire logic frame_last
);

  a_idle_after_reset: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result shown right after reset");

  a_last_is_border: assert property (@(posedge clk) disable iff (rst)
    (res_valid && frame_last) |-> !edge_res)
    else $error("last item of frame marked as edge");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_stall) |=> (res_valid && $stable(edge_res) && $stable(frame_last)))
    else $error("stalled result changed");

  a_result_has_source: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(pix_valid && !pix_stall, 5))
    else $error("result appeared without an item accepted five cycles before");

endmodule

bind canny_nonmax_suppression cnms_check u_cnms_check (.*);

`default_nettype wire
